// File: sv/two_link_arm_inverse_kinematics_top_macros.svh
// Assertion helpers for the top file, which checks its own logic.
`ifndef TWO_LINK_ARM_INVERSE_KINEMATICS_TOP_MACROS_SVH
`define TWO_LINK_ARM_INVERSE_KINEMATICS_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and ignored during reset.
`define TLIK_ASSERT_IMPLY(name, cond, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("tlik: same-cycle check failed");

// Next-cycle implication, sampled on clk and ignored during reset.
`define TLIK_ASSERT_NEXT(name, cond, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("tlik: next-cycle check failed");

`endif

// File: sv/tlik_pkg.sv
package tlik_pkg;

	localparam int POS_W = 20;
	localparam int LEN_W = 16;
	localparam int DELTA_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_UPPER_LEN = 1'b0,
		CFG_LOWER_LEN = 1'b1
	} cfg_idx_t;

	localparam logic [LEN_W-1:0] UPPER_LEN_RST = 16'd14592;
	localparam logic [LEN_W-1:0] LOWER_LEN_RST = 16'd20224;
	localparam logic signed [POS_W-1:0] WRIST_X_RST = -20'sd7588;
	localparam logic signed [POS_W-1:0] WRIST_Y_RST = 20'sd7296;

	localparam int SH_MAX = 34560;
	localparam int EL_MIN = 1920;
	localparam int EL_MAX = 13440;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
	} point_t;

	typedef struct packed {
		logic [15:0] shoulder;
		logic [13:0] elbow;
		logic [11:0] ticks0;
		logic [11:0] ticks1;
		logic signed [POS_W-1:0] wx;
		logic signed [POS_W-1:0] wy;
		logic signed [POS_W-1:0] ex;
		logic signed [POS_W-1:0] ey;
		logic unreach;
	} result_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ROOT_INIT,
		ST_ROOT,
		ST_DEN,
		ST_DIV_INIT,
		ST_DIV,
		ST_ACOS_SQ0,
		ST_ACOS_SQ1,
		ST_ACOS_ROOT,
		ST_ATAN_INIT,
		ST_ATAN,
		ST_THETA,
		ST_SC_INIT,
		ST_SINCOS,
		ST_ELBOW,
		ST_SCALE,
		ST_PULSE,
		ST_TICKS,
		ST_DONE
	} solve_state_t;

endpackage

// File: sv/tlik_front.sv
module tlik_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [tlik_pkg::DELTA_W-1:0] delta_x,
	input  logic signed [tlik_pkg::DELTA_W-1:0] delta_y,
	input  logic q_full,
	output logic q_push,
	output tlik_pkg::point_t q_data
);
	import tlik_pkg::*;

	localparam logic signed [POS_W:0] POS_HI = (POS_W+1)'((1 << (POS_W-1)) - 1);
	localparam logic signed [POS_W:0] POS_LO = -(POS_W+1)'(1 << (POS_W-1));

	logic signed [POS_W-1:0] wrist_x_q, wrist_y_q;
	logic signed [POS_W:0] sum_x, sum_y;

	function automatic logic signed [POS_W-1:0] sat(input logic signed [POS_W:0] v);
		logic signed [POS_W:0] r;
		r = v;
		if (v > POS_HI) r = POS_HI;
		if (v < POS_LO) r = POS_LO;
		return r[POS_W-1:0];
	endfunction

	assign in_stall = q_full;
	assign q_push = in_valid && !q_full;
	assign sum_x = (POS_W+1)'(wrist_x_q) + (POS_W+1)'(delta_x);
	assign sum_y = (POS_W+1)'(wrist_y_q) + (POS_W+1)'(delta_y);
	assign q_data.x = sat(sum_x);
	assign q_data.y = sat(sum_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrist_x_q <= WRIST_X_RST;
			wrist_y_q <= WRIST_Y_RST;
		end else if (q_push) begin
			wrist_x_q <= q_data.x;
			wrist_y_q <= q_data.y;
		end
	end

endmodule

// File: sv/tlik_queue.sv
module tlik_queue #(
	parameter int DEPTH = tlik_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tlik_pkg::point_t push_data,
	input  logic pop,
	output tlik_pkg::point_t pop_data,
	output logic not_empty,
	output logic full,
	output logic [$clog2(DEPTH+1)-1:0] level
);
	import tlik_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	point_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign not_empty = (cnt_q != '0);
	assign full = (cnt_q == CNT_W'(DEPTH));
	assign level = cnt_q;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/tlik_back.sv
module tlik_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  tlik_pkg::point_t q_data,
	output logic q_pop,
	input  logic [tlik_pkg::LEN_W-1:0] upper_len,
	input  logic [tlik_pkg::LEN_W-1:0] lower_len,
	output logic out_valid,
	input  logic out_stall,
	output tlik_pkg::result_t res
);
	import tlik_pkg::*;

	localparam int SQ_W = 62;
	localparam int DIV_W = 52;
	localparam int CW = 36;
	localparam int ZW = 28;
	localparam int DEG = 65536;
	localparam logic [4:0] SQRT_LAST = 5'd30;
	localparam logic [4:0] DIV_LAST = 5'd29;
	localparam logic [4:0] CORDIC_LAST = 5'd19;
	localparam logic [SQ_W-1:0] SQ_TOP = SQ_W'(1) << 60;
	localparam logic signed [31:0] QONE = 32'sd1073741824;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 36'sd652032874;
	localparam logic signed [ZW-1:0] DEG90 = ZW'(90 * DEG);
	localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * DEG);
	localparam logic signed [ZW-1:0] DEG210 = ZW'(210 * DEG);
	localparam logic signed [ZW-1:0] DEG360 = ZW'(360 * DEG);
	localparam logic signed [52:0] B_ROUND = 53'sd536870912;
	// floor(x / 9) for x below 2^16 and floor(x / 625) for x below 2^20.
	localparam logic [31:0] DIV9_MUL = 32'd58255;
	localparam int DIV9_SHIFT = 19;
	localparam logic [41:0] DIV625_MUL = 42'd1717987;
	localparam int DIV625_SHIFT = 30;

	solve_state_t st_q, st_d;
	logic [4:0] cnt_q;
	logic out_valid_q, load_out;
	result_t res_q;

	logic signed [POS_W-1:0] ax_q, ay_q;
	logic [39:0] ax2_q, ay2_q, r2_q;
	logic [31:0] uu_q, ll_q, ul_q;

	logic [SQ_W-1:0] sv_q [2];
	logic [SQ_W-1:0] sr_q [2];
	logic [SQ_W-1:0] sb_q;
	logic [SQ_W-1:0] sq_sum [2];
	logic sq_ge [2];

	logic [DIV_W-1:0] rem_q [2];
	logic [DIV_W-1:0] den_q [2];
	logic [29:0] quo_q [2];
	logic neg_q [2];
	logic special_q [2];
	logic clip_q;
	logic [DIV_W:0] rem2 [2];
	logic dv_ge [2];
	logic [DIV_W-1:0] num [2];
	logic signed [31:0] cval [2];
	logic [30:0] cmag [2];

	logic signed [CW-1:0] cx_q [3];
	logic signed [CW-1:0] cy_q [3];
	logic signed [ZW-1:0] cz_q [3];
	logic zero_q [3];
	logic signed [CW-1:0] ix [3];
	logic signed [CW-1:0] iy [3];
	logic signed [CW-1:0] shx [3];
	logic signed [CW-1:0] shy [3];
	logic dir [3];
	logic rot;
	logic signed [ZW-1:0] at;

	logic signed [ZW-1:0] theta1_q, theta2_q;
	logic signed [ZW-1:0] acos0, acos1, atpt;
	logic signed [ZW-1:0] t1, t2, t3;
	logic flip_d, flip_q;
	logic signed [CW-1:0] co, si;
	logic signed [52:0] pbx, pby;

	logic [15:0] sh_q;
	logic [13:0] el_q;
	logic signed [POS_W-1:0] ex_q, ey_q;
	logic [15:0] x95_q [2];
	logic [12:0] pulse_q [2];
	logic [11:0] tk_q [2];

	function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
		logic signed [ZW-1:0] a;
		unique case (i)
			5'd0: a = ZW'(2949120);
			5'd1: a = ZW'(1740967);
			5'd2: a = ZW'(919879);
			5'd3: a = ZW'(466945);
			5'd4: a = ZW'(234379);
			5'd5: a = ZW'(117304);
			5'd6: a = ZW'(58666);
			5'd7: a = ZW'(29335);
			5'd8: a = ZW'(14668);
			5'd9: a = ZW'(7334);
			5'd10: a = ZW'(3667);
			5'd11: a = ZW'(1833);
			5'd12: a = ZW'(917);
			5'd13: a = ZW'(458);
			5'd14: a = ZW'(229);
			5'd15: a = ZW'(115);
			5'd16: a = ZW'(57);
			5'd17: a = ZW'(29);
			5'd18: a = ZW'(14);
			5'd19: a = ZW'(7);
			default: a = '0;
		endcase
		return a;
	endfunction

	// Clamp to [lo, hi] in 1/64 degree, then round from 1/65536 degree.
	function automatic logic [15:0] to_64ths(input logic signed [ZW:0] f, input int lo,
			input int hi);
		logic signed [ZW:0] v;
		v = f;
		if (v < (ZW+1)'(lo * 1024)) v = (ZW+1)'(lo * 1024);
		if (v > (ZW+1)'(hi * 1024)) v = (ZW+1)'(hi * 1024);
		v = (v + (ZW+1)'(512)) >>> 10;
		return v[15:0];
	endfunction

	function automatic logic signed [ZW-1:0] acos_clamp(input logic signed [ZW-1:0] z,
			input logic zero);
		logic signed [ZW-1:0] a;
		a = zero ? '0 : z;
		if (a < 0) a = '0;
		if (a > DEG180) a = DEG180;
		return a;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			cnt_q <= (st_d == st_q) ? cnt_q + 1'b1 : '0;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		st_d = st_q;
		q_pop = 1'b0;
		load_out = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					st_d = ST_SQUARE;
				end
			end
			ST_SQUARE: st_d = ST_ROOT_INIT;
			ST_ROOT_INIT: st_d = ST_ROOT;
			ST_ROOT: if (cnt_q == SQRT_LAST) st_d = ST_DEN;
			ST_DEN: st_d = ST_DIV_INIT;
			ST_DIV_INIT: st_d = ST_DIV;
			ST_DIV: if (cnt_q == DIV_LAST) st_d = ST_ACOS_SQ0;
			ST_ACOS_SQ0: st_d = ST_ACOS_SQ1;
			ST_ACOS_SQ1: st_d = ST_ACOS_ROOT;
			ST_ACOS_ROOT: if (cnt_q == SQRT_LAST) st_d = ST_ATAN_INIT;
			ST_ATAN_INIT: st_d = ST_ATAN;
			ST_ATAN: if (cnt_q == CORDIC_LAST) st_d = ST_THETA;
			ST_THETA: st_d = ST_SC_INIT;
			ST_SC_INIT: st_d = ST_SINCOS;
			ST_SINCOS: if (cnt_q == CORDIC_LAST) st_d = ST_ELBOW;
			ST_ELBOW: st_d = ST_SCALE;
			ST_SCALE: st_d = ST_PULSE;
			ST_PULSE: st_d = ST_TICKS;
			ST_TICKS: st_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// Datapath helpers for the shared iterative units.
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			sq_sum[k] = sr_q[k] + sb_q;
			sq_ge[k] = (sv_q[k] >= sq_sum[k]);
			rem2[k] = {rem_q[k], 1'b0};
			dv_ge[k] = (rem2[k] >= {1'b0, den_q[k]});
			if (special_q[k]) begin
				cval[k] = neg_q[k] ? -QONE : QONE;
			end else begin
				cval[k] = neg_q[k] ? -$signed({2'b00, quo_q[k]}) : $signed({2'b00, quo_q[k]});
			end
			cmag[k] = cval[k][31] ? 31'(-cval[k]) : cval[k][30:0];
		end
		num[0] = {20'b0, uu_q} + {20'b0, ll_q} - {12'b0, r2_q};
		num[1] = ({20'b0, ll_q} + {12'b0, r2_q} - {20'b0, uu_q}) << 8;

		ix[0] = CW'(cval[0]);
		iy[0] = $signed({5'b0, sr_q[0][30:0]});
		ix[1] = CW'(cval[1]);
		iy[1] = $signed({5'b0, sr_q[1][30:0]});
		ix[2] = CW'($signed({ax_q, 12'b0}));
		iy[2] = CW'($signed({ay_q, 12'b0}));

		rot = (st_q == ST_SINCOS);
		at = atan_tab(cnt_q);
		for (int k = 0; k < 3; k++) begin
			shx[k] = cx_q[k] >>> cnt_q;
			shy[k] = cy_q[k] >>> cnt_q;
			dir[k] = rot ? !cz_q[k][ZW-1] : cy_q[k][CW-1];
		end

		acos0 = acos_clamp(cz_q[0], zero_q[0]);
		acos1 = acos_clamp(cz_q[1], zero_q[1]);
		atpt = zero_q[2] ? '0 : cz_q[2];

		t1 = (theta1_q > DEG180) ? theta1_q - DEG360 : theta1_q;
		t2 = (t1 <= -DEG180) ? t1 + DEG360 : t1;
		flip_d = 1'b1;
		if (t2 > DEG90) begin
			t3 = t2 - DEG180;
		end else if (t2 < -DEG90) begin
			t3 = t2 + DEG180;
		end else begin
			t3 = t2;
			flip_d = 1'b0;
		end

		co = flip_q ? -cx_q[0] : cx_q[0];
		si = flip_q ? -cy_q[0] : cy_q[0];
		pbx = $signed({1'b0, lower_len}) * co + B_ROUND;
		pby = $signed({1'b0, lower_len}) * si + B_ROUND;
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				ax_q <= q_data.x;
				ay_q <= q_data.y;
			end
			ST_SQUARE: begin
				ax2_q <= 40'(ax_q * ax_q);
				ay2_q <= 40'(ay_q * ay_q);
				uu_q <= upper_len * upper_len;
				ll_q <= lower_len * lower_len;
				ul_q <= upper_len * lower_len;
			end
			ST_ROOT_INIT: begin
				r2_q <= ax2_q + ay2_q;
				sv_q[0] <= {6'b0, ax2_q + ay2_q, 16'b0};
				sr_q[0] <= '0;
				sb_q <= SQ_TOP;
			end
			ST_ROOT, ST_ACOS_ROOT: begin
				for (int k = 0; k < 2; k++) begin
					if (sq_ge[k]) begin
						sv_q[k] <= sv_q[k] - sq_sum[k];
						sr_q[k] <= (sr_q[k] >> 1) + sb_q;
					end else begin
						sr_q[k] <= sr_q[k] >> 1;
					end
				end
				sb_q <= sb_q >> 2;
			end
			ST_DEN: begin
				den_q[0] <= {19'b0, ul_q, 1'b0};
				den_q[1] <= {7'b0, 44'(lower_len * sr_q[0][27:0]), 1'b0};
				for (int k = 0; k < 2; k++) begin
					neg_q[k] <= num[k][DIV_W-1];
					rem_q[k] <= num[k][DIV_W-1] ? -num[k] : num[k];
				end
			end
			ST_DIV_INIT: begin
				// A zero denominator or a ratio of magnitude one or more gives +-1.
				for (int k = 0; k < 2; k++) begin
					special_q[k] <= (den_q[k] == '0) || (rem_q[k] >= den_q[k]);
					quo_q[k] <= '0;
				end
				clip_q <= (den_q[0] == '0) || (rem_q[0] > den_q[0]) ||
					(den_q[1] == '0) || (rem_q[1] > den_q[1]);
			end
			ST_DIV: begin
				for (int k = 0; k < 2; k++) begin
					rem_q[k] <= dv_ge[k] ? DIV_W'(rem2[k] - {1'b0, den_q[k]}) : rem2[k][DIV_W-1:0];
					quo_q[k] <= {quo_q[k][28:0], dv_ge[k]};
				end
			end
			ST_ACOS_SQ0: begin
				sv_q[0] <= SQ_TOP - cmag[0] * cmag[0];
				sr_q[0] <= '0;
			end
			ST_ACOS_SQ1: begin
				sv_q[1] <= SQ_TOP - cmag[1] * cmag[1];
				sr_q[1] <= '0;
				sb_q <= SQ_TOP;
			end
			ST_ATAN_INIT: begin
				// Vectors in the left half plane are turned by half a revolution first.
				for (int k = 0; k < 3; k++) begin
					zero_q[k] <= (ix[k] == '0) && (iy[k] == '0);
					if (ix[k] < 0) begin
						cx_q[k] <= -ix[k];
						cy_q[k] <= -iy[k];
						cz_q[k] <= (iy[k] >= 0) ? DEG180 : -DEG180;
					end else begin
						cx_q[k] <= ix[k];
						cy_q[k] <= iy[k];
						cz_q[k] <= '0;
					end
				end
			end
			ST_ATAN, ST_SINCOS: begin
				for (int k = 0; k < 3; k++) begin
					if (dir[k]) begin
						cx_q[k] <= cx_q[k] - shy[k];
						cy_q[k] <= cy_q[k] + shx[k];
						cz_q[k] <= cz_q[k] - at;
					end else begin
						cx_q[k] <= cx_q[k] + shy[k];
						cy_q[k] <= cy_q[k] - shx[k];
						cz_q[k] <= cz_q[k] + at;
					end
				end
			end
			ST_THETA: begin
				theta2_q <= acos0;
				theta1_q <= atpt - acos1;
			end
			ST_SC_INIT: begin
				cx_q[0] <= CORDIC_GAIN;
				cy_q[0] <= '0;
				cz_q[0] <= t3;
				flip_q <= flip_d;
			end
			ST_ELBOW: begin
				ex_q <= pbx[49:30];
				ey_q <= pby[49:30];
				sh_q <= to_64ths((ZW+1)'(DEG180) - (ZW+1)'(theta1_q), 0, SH_MAX);
				el_q <= 14'(to_64ths((ZW+1)'(DEG210) - (ZW+1)'(theta2_q), EL_MIN, EL_MAX));
			end
			ST_SCALE: begin
				x95_q[0] <= 16'(sh_q[15:6] * 7'd95);
				x95_q[1] <= 16'(el_q[13:6] * 7'd95);
			end
			ST_PULSE: begin
				for (int k = 0; k < 2; k++) begin
					pulse_q[k] <= 13'(13'd500 + 13'(({16'b0, x95_q[k]} * DIV9_MUL) >> DIV9_SHIFT));
				end
			end
			ST_TICKS: begin
				for (int k = 0; k < 2; k++) begin
					tk_q[k] <= 12'(({22'b0, pulse_q[k], 7'b0} * DIV625_MUL) >> DIV625_SHIFT);
				end
			end
			ST_DONE: begin
				if (load_out) begin
					res_q.shoulder <= sh_q;
					res_q.elbow <= el_q;
					res_q.ticks0 <= tk_q[0];
					res_q.ticks1 <= tk_q[1];
					res_q.wx <= ax_q;
					res_q.wy <= ay_q;
					res_q.ex <= ex_q;
					res_q.ey <= ey_q;
					res_q.unreach <= clip_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign res = res_q;

endmodule

// File: sv/two_link_arm_inverse_kinematics_top.sv
// Channel  Direction  Handshake             Payload
// request  in         in_valid / in_stall   delta_x, delta_y
// result   out        out_valid / out_stall shoulder_angle .. unreachable
// config   in         cfg_we                cfg_index, cfg_wdata
//
// Each request runs the solver through three 31-step square roots (two run side by side),
// two 30-step divisions side by side, 20-step CORDIC passes for the three arctangents
// and then for sine and cosine, and 15 setup, scaling and hand-off steps.
// A two-entry queue takes new requests while the solver works; a stalled result holds the
// solver in its last step, and the request side stalls once the queue is full.
// Reset puts the wrist point at (-7588, 7296) and the link lengths at 14592 and 20224.
module two_link_arm_inverse_kinematics_top #(
	parameter int QUEUE_DEPTH = tlik_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [tlik_pkg::DELTA_W-1:0] delta_x,
	input  logic signed [tlik_pkg::DELTA_W-1:0] delta_y,
	output logic out_valid,
	input  logic out_stall,
	output logic [15:0] shoulder_angle,
	output logic [13:0] elbow_angle,
	output logic [11:0] servo0_ticks,
	output logic [11:0] servo1_ticks,
	output logic signed [tlik_pkg::POS_W-1:0] new_wrist_x,
	output logic signed [tlik_pkg::POS_W-1:0] new_wrist_y,
	output logic signed [tlik_pkg::POS_W-1:0] new_elbow_x,
	output logic signed [tlik_pkg::POS_W-1:0] new_elbow_y,
	output logic unreachable,
	input  logic cfg_we,
	input  logic [tlik_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tlik_pkg::LEN_W-1:0] cfg_wdata
);
	import tlik_pkg::*;

	`include "two_link_arm_inverse_kinematics_top_macros.svh"

	logic [LEN_W-1:0] upper_len_q, lower_len_q;
	logic q_push, q_pop, q_full, q_valid;
	point_t q_in, q_out;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_level;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_len_q <= UPPER_LEN_RST;
			lower_len_q <= LOWER_LEN_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_UPPER_LEN) begin
				upper_len_q <= cfg_wdata;
			end else if (cfg_index == CFG_LOWER_LEN) begin
				lower_len_q <= cfg_wdata;
			end
		end
	end

	tlik_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.delta_x(delta_x),
		.delta_y(delta_y),
		.q_full(q_full),
		.q_push(q_push),
		.q_data(q_in)
	);

	tlik_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(q_in),
		.pop(q_pop),
		.pop_data(q_out),
		.not_empty(q_valid),
		.full(q_full),
		.level(q_level)
	);

	tlik_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_data(q_out),
		.q_pop(q_pop),
		.upper_len(upper_len_q),
		.lower_len(lower_len_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.res(res)
	);

	assign shoulder_angle = res.shoulder;
	assign elbow_angle = res.elbow;
	assign servo0_ticks = res.ticks0;
	assign servo1_ticks = res.ticks1;
	assign new_wrist_x = res.wx;
	assign new_wrist_y = res.wy;
	assign new_elbow_x = res.ex;
	assign new_elbow_y = res.ey;
	assign unreachable = res.unreach;

	`TLIK_ASSERT_IMPLY(a_elbow_range, out_valid, (elbow_angle >= 14'(EL_MIN)) && (elbow_angle <= 14'(EL_MAX)))
	`TLIK_ASSERT_IMPLY(a_shoulder_range, out_valid, shoulder_angle <= 16'(SH_MAX))
	`TLIK_ASSERT_NEXT(a_queue_holds, in_valid && !in_stall, q_level != '0)

endmodule

// File: tb/tlik_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and register channels, models the arm solver and
// compares every result against the oldest predicted one.
module tlik_checker
	import tlik_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  logic signed [DELTA_W-1:0] delta_x,
	input  logic signed [DELTA_W-1:0] delta_y,
	input  logic out_valid,
	input  logic out_stall,
	input  logic [15:0] shoulder_angle,
	input  logic [13:0] elbow_angle,
	input  logic [11:0] servo0_ticks,
	input  logic [11:0] servo1_ticks,
	input  logic signed [POS_W-1:0] new_wrist_x,
	input  logic signed [POS_W-1:0] new_wrist_y,
	input  logic signed [POS_W-1:0] new_elbow_x,
	input  logic signed [POS_W-1:0] new_elbow_y,
	input  logic unreachable,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEN_W-1:0] cfg_wdata,
	output int fail_count,
	output int pending,
	output int results_seen,
	output int unreach_seen
);

	localparam longint DEG = 65536;
	localparam longint QONE = 64'sd1 << 30;
	localparam longint GAIN = 652032874;
	localparam int POS_MAX = 524287;
	localparam int POS_MIN = -524288;
	localparam longint ATAN_STEP [20] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
	};

	logic [LEN_W-1:0] upper_len, lower_len;
	int arm_wx, arm_wy;
	bit clamp_hit;
	result_t expected_results[$];

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint vec_angle(longint y, longint x);
		longint z, dx, dy;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			z = (y >= 0) ? 180 * DEG : -180 * DEG;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 20; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx; y = y - dy; z = z + ATAN_STEP[i];
			end else begin
				x = x - dx; y = y + dy; z = z - ATAN_STEP[i];
			end
		end
		return z;
	endfunction

	function automatic longint arc_cos(longint c);
		longint unsigned m;
		longint s, a;
		m = (c < 0) ? -c : c;
		s = int_sqrt((64'd1 << 60) - m * m);
		a = vec_angle(s, c);
		if (a < 0) a = 0;
		if (a > 180 * DEG) a = 180 * DEG;
		return a;
	endfunction

	// Cosine of a triangle angle in Q30; an argument beyond one is clamped and flagged.
	function automatic longint cos_ratio(longint num, longint den);
		longint unsigned mag, rem, q;
		if (den <= 0) begin
			clamp_hit = 1;
			return (num < 0) ? -QONE : QONE;
		end
		mag = (num < 0) ? -num : num;
		if (mag >= den) begin
			if (mag > den) clamp_hit = 1;
			return (num < 0) ? -QONE : QONE;
		end
		rem = mag;
		q = 0;
		for (int i = 0; i < 30; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				rem = rem - den;
				q = q | 1;
			end
		end
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	task automatic rotate(input longint t, output longint co, output longint si);
		longint x, y, dx, dy;
		bit flip;
		x = GAIN;
		y = 0;
		flip = 0;
		if (t > 180 * DEG) t = t - 360 * DEG;
		if (t <= -180 * DEG) t = t + 360 * DEG;
		if (t > 90 * DEG) begin
			t = t - 180 * DEG; flip = 1;
		end else if (t < -90 * DEG) begin
			t = t + 180 * DEG; flip = 1;
		end
		for (int i = 0; i < 20; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (t >= 0) begin
				x = x - dx; y = y + dy; t = t - ATAN_STEP[i];
			end else begin
				x = x + dx; y = y - dy; t = t + ATAN_STEP[i];
			end
		end
		co = flip ? -x : x;
		si = flip ? -y : y;
	endtask

	function automatic int clamp_pos(int v);
		return (v > POS_MAX) ? POS_MAX : ((v < POS_MIN) ? POS_MIN : v);
	endfunction

	function automatic longint to_units(longint f, longint lo, longint hi);
		if (f < lo * 1024) f = lo * 1024;
		if (f > hi * 1024) f = hi * 1024;
		f = (f + 512) >>> 10;
		return (f > hi) ? hi : f;
	endfunction

	function automatic longint pwm_count(longint angle);
		longint d, pulse;
		d = angle >>> 6;
		pulse = 500 + 1900 * d / 180;
		return pulse * 4096 / 20000;
	endfunction

	task automatic solve_arm(input int dx, input int dy);
		longint u, l, ax, ay, r2, s, c1, c2, th1, th2, co, si, sh, el;
		result_t res;
		u = upper_len;
		l = lower_len;
		clamp_hit = 0;
		arm_wx = clamp_pos(arm_wx + dx);
		arm_wy = clamp_pos(arm_wy + dy);
		ax = arm_wx;
		ay = arm_wy;
		r2 = ax * ax + ay * ay;
		s = int_sqrt(r2 << 16);
		c2 = cos_ratio(u * u + l * l - r2, 2 * u * l);
		c1 = cos_ratio((l * l + r2 - u * u) * 256, 2 * l * s);
		th2 = arc_cos(c2);
		th1 = vec_angle(ay * 4096, ax * 4096) - arc_cos(c1);
		sh = to_units(180 * DEG - th1, 0, SH_MAX);
		el = to_units(210 * DEG - th2, EL_MIN, EL_MAX);
		rotate(th1, co, si);
		res.shoulder = sh[15:0];
		res.elbow = el[13:0];
		res.ticks0 = 12'(pwm_count(sh));
		res.ticks1 = 12'(pwm_count(el));
		res.wx = POS_W'(arm_wx);
		res.wy = POS_W'(arm_wy);
		res.ex = POS_W'((l * co + (64'sd1 << 29)) >>> 30);
		res.ey = POS_W'((l * si + (64'sd1 << 29)) >>> 30);
		res.unreach = clamp_hit;
		expected_results.push_back(res);
	endtask

	function automatic int field_ok(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			return 0;
		end
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		int good;
		if (!arst_n) begin
			upper_len <= UPPER_LEN_RST;
			lower_len <= LOWER_LEN_RST;
			arm_wx = int'(WRIST_X_RST);
			arm_wy = int'(WRIST_Y_RST);
			expected_results.delete();
			fail_count <= 0;
			results_seen <= 0;
			unreach_seen <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_UPPER_LEN: upper_len <= cfg_wdata;
					CFG_LOWER_LEN: lower_len <= cfg_wdata;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					$error("result arrived with no request outstanding");
					fail_count <= fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (want.unreach) unreach_seen <= unreach_seen + 1;
					good = 1;
					good &= field_ok("shoulder_angle", want.shoulder, shoulder_angle);
					good &= field_ok("elbow_angle", want.elbow, elbow_angle);
					good &= field_ok("servo0_ticks", want.ticks0, servo0_ticks);
					good &= field_ok("servo1_ticks", want.ticks1, servo1_ticks);
					good &= field_ok("new_wrist_x", want.wx, new_wrist_x);
					good &= field_ok("new_wrist_y", want.wy, new_wrist_y);
					good &= field_ok("new_elbow_x", want.ex, new_elbow_x);
					good &= field_ok("new_elbow_y", want.ey, new_elbow_y);
					good &= field_ok("unreachable", want.unreach, unreachable);
					if (!good) fail_count <= fail_count + 1;
				end
			end
			// The request is modeled after the result compare, so a result never
			// meets an expectation from the same edge.
			if (in_valid && !in_stall) solve_arm(delta_x, delta_y);
		end
	end

	assign pending = expected_results.size();

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import tlik_pkg::*;

	localparam int IDLE_LIMIT = 6000;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [DELTA_W-1:0] delta_x, delta_y;
	logic [15:0] shoulder_angle;
	logic [13:0] elbow_angle;
	logic [11:0] servo0_ticks, servo1_ticks;
	logic signed [POS_W-1:0] new_wrist_x, new_wrist_y, new_elbow_x, new_elbow_y;
	logic unreachable;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LEN_W-1:0] cfg_wdata;
	int fail_count, pending, results_seen, unreach_seen;
	int requests_sent, quiet_cycles;
	bit quiet, hold_req;

	two_link_arm_inverse_kinematics_top i_dut (.*);

	tlik_checker i_checker (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// The result side stalls at random, not at all in a quiet phase, or for one long
	// stretch when asked, so that the request queue fills up behind it.
	initial begin
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1;
				repeat (500) @(negedge clk);
				hold_req = 0;
			end else begin
				out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 37);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("timeout with %0d results outstanding", pending);
			$display("testbench failed");
			$finish;
		end
	end

	task automatic send_move(input int dx, input int dy);
		if (!quiet && $urandom_range(99) < 37) begin
			in_valid <= 0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
		end
		in_valid <= 1;
		delta_x <= DELTA_W'(dx);
		delta_y <= DELTA_W'(dy);
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [LEN_W-1:0] value);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	function automatic int pick_delta();
		int sel;
		sel = $urandom_range(99);
		if (sel < 60) return $urandom_range(6000) - 3000;
		if (sel < 80) return $urandom_range(65535) - 32768;
		if (sel < 90) return $urandom_range(1) ? 32767 : -32768;
		return $urandom_range(400) - 200;
	endfunction

	// Mostly small moves that keep the wrist near the arm, with runs of full-scale
	// moves that drive the wrist out of reach and into saturation.
	task automatic random_moves(input int count);
		int dx, dy, run;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 8) begin
				dx = $urandom_range(1) ? 32767 : -32768;
				dy = $urandom_range(1) ? 32767 : -32768;
				run = $urandom_range(20, 4);
				for (int k = 0; k < run; k++) send_move(dx, dy);
				n += run - 1;
			end else begin
				send_move(pick_delta(), pick_delta());
			end
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		delta_x = 0;
		delta_y = 0;
		cfg_we = 0;
		cfg_index = CFG_UPPER_LEN;
		cfg_wdata = 0;
		quiet = 0;
		hold_req = 0;
		requests_sent = 0;
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Default lengths: zero move, field extremes, and the wrist sent to (-2, -2) near the origin.
		send_move(0, 0);
		send_move(32767, 32767);
		send_move(-32768, -32768);
		send_move(32767, -32768);
		send_move(-32768, 32767);
		send_move(1, -1);
		send_move(-1, 1);
		send_move(7588, -7296);
		send_move(0, 0);
		send_move(-21000, 0);
		send_move(0, 21000);
		send_move(-15000, -12000);
		drain();

		// Degenerate arm: zero upper link and a lower link of length one.
		write_reg(CFG_UPPER_LEN, 16'd0);
		write_reg(CFG_LOWER_LEN, 16'd1);
		send_move(0, 0);
		send_move(1, 0);
		random_moves(100);
		drain();

		write_reg(CFG_UPPER_LEN, 16'hFFFF);
		write_reg(CFG_LOWER_LEN, 16'hFFFF);
		hold_req = 1;
		random_moves(130);
		drain();

		write_reg(CFG_UPPER_LEN, 16'd14592);
		write_reg(CFG_LOWER_LEN, 16'd20224);
		quiet = 1;
		random_moves(140);
		quiet = 0;
		drain();

		write_reg(CFG_UPPER_LEN, LEN_W'($urandom_range(65535)));
		write_reg(CFG_LOWER_LEN, LEN_W'($urandom_range(65535, 1)));
		random_moves(140);
		drain();

		write_reg(CFG_UPPER_LEN, 16'd30000);
		write_reg(CFG_LOWER_LEN, 16'd9000);
		random_moves(130);
		drain();
		repeat (200) @(negedge clk);

		$display("%0d requests over six link settings, %0d results checked, %0d out of reach",
			requests_sent, results_seen, unreach_seen);
		if (fail_count == 0 && pending == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
